/* hw/rtl/bbf_pkg.sv */
`timescale 1ns / 1ps
package bbf_pkg;

  // Default limits of the frame and of the averaging window.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_KERNEL = 15;

  // Colour channels per pixel, bits per channel and bits per position field.
  localparam int LANES = 3;
  localparam int PIX_W = 8;
  localparam int POS_W = 11;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_FIN
  } bbf_state_t;

endpackage

/* hw/rtl/rgb_box_blur_filter_top.sv */
`timescale 1ns / 1ps
// Box blur of a raster-order stream of three-channel 8-bit pixels.
// Input beats: in_tuser is 1 for an image pixel and 0 for a flush tick;
// flush ticks after the frame push out the outputs still held back.
// Each output beat carries the truncated per-channel mean of the k-by-k
// window around one pixel, its column and row, and tlast on the last pixel.
// The configuration channel (always ready) sets width, height and window
// size; a write to one of these restarts the frame. Write only while the block is idle.
// One input beat is taken at a time. A beat that causes an output passes
// through the one-pixel-a-cycle window scan of the line store and the
// eight-cell divider chain. The next beat is accepted while an output
// waits to be taken.
// When the receiver stalls, the finished beat holds on the output register;
// a further result waits in the sequencer and input is then held off.
// Reset (synchronous, active low) clears the counters and restores
// 640 x 480 with a 3 x 3 window; the line store is not cleared.
module rgb_box_blur_filter_top #(
  parameter int MAX_WIDTH  = bbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = bbf_pkg::DEF_MAX_KERNEL
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: chan_a[7:0], chan_b[15:8], chan_c[23:16]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // in_tuser: is_pixel[0]
  input  logic        in_tuser,
  // out_tdata: mean_a[7:0], mean_b[15:8], mean_c[23:16], pos_x[34:24],
  // pos_y[45:35], zero padding [47:46]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import bbf_pkg::*;

  localparam int LS_ROWS = MAX_KERNEL + 2;
  localparam int SW      = $clog2(LS_ROWS);
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int RW      = $clog2(MAX_HEIGHT + 1);
  localparam int KW      = $clog2(MAX_KERNEL + 1);
  localparam int SUMW    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int CNTW    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int NCELL   = PIX_W;
  localparam int W_RST   = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int H_RST   = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
  localparam int K_RST   = (MAX_KERNEL < 3) ? MAX_KERNEL : 3;

  bbf_state_t state_r, state_nxt;

  logic [CW-1:0] w_r, w_nxt;
  logic [RW-1:0] h_r, h_nxt;
  logic [KW-1:0] k_r, k_nxt;

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;

  logic [KW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic signed [RW+1:0] yy_r, yy_nxt;
  logic signed [CW+1:0] xx_r, xx_nxt, x0_r, x0_nxt;
  logic [SW-1:0] ys_r, ys_nxt;
  logic acc_en_r, acc_en_nxt;
  logic [LANES-1:0][SUMW-1:0] sum_r, sum_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [LANES-1:0][PIX_W-1:0] q_hold_r, q_hold_nxt;

  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [LANES-1:0][PIX_W-1:0] out_mean_r, out_mean_nxt;
  logic [POS_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic [KW-1:0] o_w, r_w;
  logic [RW:0] ny;
  logic [CW:0] nx;
  logic ready_out, in_win, wr_en, cfg_hit, out_free;
  logic [LANES*PIX_W-1:0] rd_data;

  // Divider chain taps.
  logic                         v_s   [NCELL+1];
  logic [CNTW-1:0]              cnt_s [NCELL+1];
  logic [LANES-1:0][SUMW-1:0]   rem_s [NCELL+1];
  logic [LANES-1:0][PIX_W-1:0]  q_s   [NCELL+1];

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                                   cfg_index == CFG_KERNEL);
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Window offset to the upper left and extent to the lower right.
  assign o_w = (k_r - KW'(1)) >> 1;
  assign r_w = k_r - KW'(1) - o_w;

  // Lowest-right window pixel that has to have arrived, clipped to the image.
  always_comb begin
    ny = (RW+1)'(out_row_r) + (RW+1)'(r_w);
    if (ny > (RW+1)'(h_r) - (RW+1)'(1)) ny = (RW+1)'(h_r) - (RW+1)'(1);
    nx = (CW+1)'(out_col_r) + (CW+1)'(r_w);
    if (nx > (CW+1)'(w_r) - (CW+1)'(1)) nx = (CW+1)'(w_r) - (CW+1)'(1);
    ready_out = ((RW+1)'(in_row_r) > ny) ||
                (((RW+1)'(in_row_r) == ny) && ((CW+1)'(in_col_r) > nx));
  end

  assign in_win = (yy_r >= 0) && (yy_r < $signed((RW+2)'(h_r))) &&
                  (xx_r >= 0) && (xx_r < $signed((CW+2)'(w_r)));
  assign wr_en  = in_tvalid && in_tready && in_tuser && (in_row_r < h_r);

  bbf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .ROWS      (LS_ROWS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_slot (in_slot_r),
    .wr_col  (in_col_r[XW-1:0]),
    .wr_data (in_tdata),
    .rd_slot (ys_r),
    .rd_col  (xx_r[XW-1:0]),
    .rd_data (rd_data)
  );

  // The chain is fed with the final sums in the cycle they settle.
  assign v_s[0]   = (state_r == S_DRAIN);
  assign cnt_s[0] = cnt_nxt;
  assign rem_s[0] = sum_nxt;
  assign q_s[0]   = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    bbf_div_cell #(
      .SUMW (SUMW),
      .CNTW (CNTW),
      .BIT  (NCELL - 1 - g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_in    (v_s[g]),
      .cnt_in  (cnt_s[g]),
      .rem_in  (rem_s[g]),
      .q_in    (q_s[g]),
      .v_out   (v_s[g+1]),
      .cnt_out (cnt_s[g+1]),
      .rem_out (rem_s[g+1]),
      .q_out   (q_s[g+1])
    );
  end

  // Sequencer, counters and configuration.
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    in_slot_nxt   = in_slot_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_slot_nxt  = out_slot_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    yy_nxt        = yy_r;
    xx_nxt        = xx_r;
    x0_nxt        = x0_r;
    ys_nxt        = ys_r;
    acc_en_nxt    = 1'b0;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    q_hold_nxt    = q_hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_mean_nxt  = out_mean_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;

    // Accumulate the pixel read in the previous cycle.
    if (acc_en_r) begin
      for (int l = 0; l < LANES; l++) begin
        sum_nxt[l] = sum_r[l] + SUMW'(rd_data[l*PIX_W +: PIX_W]);
      end
      cnt_nxt = cnt_r + CNTW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
          if (wr_en) begin
            if (in_col_r + CW'(1) >= w_r) begin
              in_col_nxt  = '0;
              in_row_nxt  = in_row_r + RW'(1);
              in_slot_nxt = (in_slot_r == SW'(LS_ROWS - 1)) ? '0 : in_slot_r + SW'(1);
            end else begin
              in_col_nxt = in_col_r + CW'(1);
            end
          end
        end
      end
      S_CHECK: begin
        if (out_row_r >= h_r || !ready_out) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
          i_nxt     = '0;
          j_nxt     = '0;
          yy_nxt    = $signed((RW+2)'(out_row_r)) - $signed((RW+2)'(o_w));
          x0_nxt    = $signed((CW+2)'(out_col_r)) - $signed((CW+2)'(o_w));
          xx_nxt    = $signed((CW+2)'(out_col_r)) - $signed((CW+2)'(o_w));
          ys_nxt    = (out_slot_r >= SW'(o_w)) ? out_slot_r - SW'(o_w) :
                      SW'(32'(out_slot_r) + LS_ROWS - 32'(o_w));
          sum_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        acc_en_nxt = in_win;
        if (j_r == k_r - KW'(1)) begin
          j_nxt  = '0;
          xx_nxt = x0_r;
          i_nxt  = i_r + KW'(1);
          yy_nxt = yy_r + (RW+2)'(1);
          ys_nxt = (ys_r == SW'(LS_ROWS - 1)) ? '0 : ys_r + SW'(1);
          if (i_r == k_r - KW'(1)) state_nxt = S_DRAIN;
        end else begin
          j_nxt  = j_r + KW'(1);
          xx_nxt = xx_r + (CW+2)'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (v_s[NCELL]) begin
          q_hold_nxt = q_s[NCELL];
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_mean_nxt  = q_hold_r;
          out_x_nxt     = POS_W'(out_col_r);
          out_y_nxt     = POS_W'(out_row_r);
          out_last_nxt  = 1'b0;
          if (out_col_r + CW'(1) >= w_r) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + RW'(1);
            out_slot_nxt = (out_slot_r == SW'(LS_ROWS - 1)) ? '0 : out_slot_r + SW'(1);
            if (out_row_r + RW'(1) >= h_r) begin
              // Frame done: every counter goes back to the start.
              out_last_nxt = 1'b1;
              out_col_nxt  = '0;
              out_row_nxt  = '0;
              out_slot_nxt = '0;
              in_col_nxt   = '0;
              in_row_nxt   = '0;
              in_slot_nxt  = '0;
            end
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write restarts the frame.
    if (cfg_hit) begin
      case (cfg_index)
        CFG_WIDTH: begin
          if (cfg_data == '0) w_nxt = CW'(1);
          else if (32'(cfg_data) > MAX_WIDTH) w_nxt = CW'(MAX_WIDTH);
          else w_nxt = CW'(cfg_data);
        end
        CFG_HEIGHT: begin
          if (cfg_data == '0) h_nxt = RW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT) h_nxt = RW'(MAX_HEIGHT);
          else h_nxt = RW'(cfg_data);
        end
        CFG_KERNEL: begin
          if (cfg_data[3:0] == '0) k_nxt = KW'(1);
          else if (32'(cfg_data[3:0]) > MAX_KERNEL) k_nxt = KW'(MAX_KERNEL);
          else k_nxt = KW'(cfg_data[3:0]);
        end
        default: begin
        end
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= CW'(W_RST);
      h_r         <= RW'(H_RST);
      k_r         <= KW'(K_RST);
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      k_r         <= k_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_slot_r   <= in_slot_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_slot_r  <= out_slot_nxt;
      acc_en_r    <= acc_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Window walk and payload.
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    yy_r       <= yy_nxt;
    xx_r       <= xx_nxt;
    x0_r       <= x0_nxt;
    ys_r       <= ys_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    q_hold_r   <= q_hold_nxt;
    out_last_r <= out_last_nxt;
    out_mean_r <= out_mean_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_y_r, out_x_r, out_mean_r[2], out_mean_r[1], out_mean_r[0]};

`ifndef SYNTH
  // A quotient only leaves the chain while the sequencer waits for it.
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    v_s[NCELL] |-> state_r == S_DIV)
    else $error("divider result outside the divide wait");

  // Pixel reads are accumulated only during the window walk.
  a_acc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("accumulate outside the window walk");

  // An accepted beat is always checked for an output next.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CHECK)
    else $error("accepted beat not checked");

  // Neither the input nor the output column ever runs past the row.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r < w_r && in_col_r < w_r)
    else $error("column counter beyond image width");
`endif

endmodule

/* hw/rtl/bbf_div_cell.sv */
`timescale 1ns / 1ps
module bbf_div_cell #(
  parameter int SUMW = 16,
  parameter int CNTW = 8,
  parameter int BIT  = 7
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    v_in,
  input  logic [CNTW-1:0]                         cnt_in,
  input  logic [bbf_pkg::LANES-1:0][SUMW-1:0]     rem_in,
  input  logic [bbf_pkg::LANES-1:0][bbf_pkg::PIX_W-1:0] q_in,
  output logic                                    v_out,
  output logic [CNTW-1:0]                         cnt_out,
  output logic [bbf_pkg::LANES-1:0][SUMW-1:0]     rem_out,
  output logic [bbf_pkg::LANES-1:0][bbf_pkg::PIX_W-1:0] q_out
);
  import bbf_pkg::*;

  localparam int EW = SUMW + PIX_W;

  logic                              v_r;
  logic [CNTW-1:0]                   cnt_r;
  logic [LANES-1:0][SUMW-1:0]        rem_r, rem_nxt;
  logic [LANES-1:0][PIX_W-1:0]       q_r, q_nxt;
  logic [EW-1:0]                     dsh;

  // One restoring step per lane: try to take the shifted divisor away.
  always_comb begin
    dsh = EW'(cnt_in) << BIT;
    for (int l = 0; l < LANES; l++) begin
      if (EW'(rem_in[l]) >= dsh) begin
        rem_nxt[l] = rem_in[l] - dsh[SUMW-1:0];
        q_nxt[l]   = q_in[l] | (PIX_W'(1) << BIT);
      end else begin
        rem_nxt[l] = rem_in[l];
        q_nxt[l]   = q_in[l];
      end
    end
  end

  // The valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_in;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign v_out   = v_r;
  assign cnt_out = cnt_r;
  assign rem_out = rem_r;
  assign q_out   = q_r;

endmodule

/* hw/rtl/bbf_line_store.sv */
`timescale 1ns / 1ps
module bbf_line_store #(
  parameter int MAX_WIDTH = 2048,
  parameter int ROWS      = 17
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [$clog2(ROWS)-1:0]                  wr_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]             wr_col,
  input  logic [bbf_pkg::LANES*bbf_pkg::PIX_W-1:0] wr_data,
  input  logic [$clog2(ROWS)-1:0]                  rd_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]             rd_col,
  output logic [bbf_pkg::LANES*bbf_pkg::PIX_W-1:0] rd_data
);
  import bbf_pkg::*;

  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = LANES * PIX_W;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] rd_r;

  // Each row slot occupies a run of MAX_WIDTH entries.
  assign wr_addr = AW'(32'(wr_slot) * MAX_WIDTH + 32'(wr_col));
  assign rd_addr = AW'(32'(rd_slot) * MAX_WIDTH + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule
